>>> hdl/stock_span_previous_greater_defines.svh
// assertion macros for the stock span block
// no dependencies; included by files that carry assertions
`ifndef STOCK_SPAN_PREVIOUS_GREATER_DEFINES_SVH
`define STOCK_SPAN_PREVIOUS_GREATER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SSPG_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sspg assertion failed");
`define SSPG_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("sspg forbidden condition");
`else
`define SSPG_ASSERT(lbl, clk, rst_n, prop)
`define SSPG_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

>>> hdl/sspg_pkg.sv
// shared constants and types for the stock span block
// no dependencies
package sspg_pkg;
	localparam int STACK_DEPTH = 1024;
	localparam int PTR_W = $clog2(STACK_DEPTH);
	localparam int CNT_W = PTR_W + 1;
	localparam int PRICE_W = 32;
	localparam int DAY_W = 32;
	localparam int ENTRY_W = PRICE_W + DAY_W;

	typedef logic signed [PRICE_W-1:0] price_t;
	typedef logic [DAY_W-1:0] day_t;

	typedef struct packed {
		day_t index;
		price_t price;
	} entry_t;
endpackage

>>> hdl/sspg_in_if.sv
// input channel: one price per transfer
// depends on sspg_pkg
interface sspg_in_if import sspg_pkg::*; ();
	logic valid;
	logic ready;
	price_t price;
	logic restart;

	modport source(output valid, price, restart, input ready);
	modport sink(input valid, price, restart, output ready);
endinterface

>>> hdl/sspg_out_if.sv
// result channel: span and previous greater price per transfer
// depends on sspg_pkg
interface sspg_out_if import sspg_pkg::*; ();
	logic valid;
	logic ready;
	day_t span;
	price_t previous_greater;
	logic greater_found;
	logic stack_overflow;

	modport source(output valid, span, previous_greater, greater_found, stack_overflow,
		input ready);
	modport sink(input valid, span, previous_greater, greater_found, stack_overflow,
		output ready);
endinterface

>>> hdl/stock_span_previous_greater.sv
// Stock span with previous strictly greater price. Each price transfer gives one result:
// the span, the nearest earlier strictly greater price with a found flag, and an overflow
// flag when the push drops the oldest entry of the STACK_DEPTH-entry stack. Each pop in the
// compare loop reads the next entry through the registered read port of the stack memory,
// and an item finishes only once the output register is free or being read. The stack memory
// needs no clearing after reset. A result may wait in the output register while the next
// price is accepted; restart clears the stack and the day counter ahead of its own price.
// depends on sspg_pkg, sspg_in_if, sspg_out_if, sspg_ram and the defines header
`include "stock_span_previous_greater_defines.svh"

module stock_span_previous_greater import sspg_pkg::*; (
	input logic clk,
	input logic arst_n,
	sspg_in_if.sink item,
	sspg_out_if.source result
);
	typedef enum logic {ST_IDLE, ST_CMP} state_t;

	localparam day_t DAY_MAX = '1;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [PTR_W-1:0] bottom_q;
	day_t day_q;
	price_t cur_q;

	logic out_valid_q;
	day_t span_q;
	price_t prev_q;
	logic found_q;
	logic ovf_q;

	logic accept;
	logic [CNT_W-1:0] cnt_eff;
	logic [PTR_W-1:0] bot_eff;
	logic [CNT_W-1:0] count_dec;
	logic have_top;
	logic pop;
	logic out_free;
	logic finish;
	logic full;
	logic rd_en;
	logic [PTR_W-1:0] rd_addr;
	logic wr_en;
	logic [PTR_W-1:0] wr_addr;
	entry_t wr_entry;
	entry_t rd_entry;
	day_t diff;
	day_t span_calc;
	logic [PTR_W-1:0] bottom_inc;

	function automatic logic [PTR_W-1:0] slot_of(input logic [PTR_W-1:0] b,
		input logic [CNT_W-1:0] off);
		logic [CNT_W-1:0] sum;
		sum = {1'b0, b} + off;
		if (sum >= CNT_W'(STACK_DEPTH)) begin
			sum = sum - CNT_W'(STACK_DEPTH);
		end
		return sum[PTR_W-1:0];
	endfunction

	assign item.ready = (state_q == ST_IDLE);
	assign accept = item.valid && item.ready;
	assign cnt_eff = item.restart ? '0 : count_q;
	assign bot_eff = item.restart ? '0 : bottom_q;
	assign count_dec = count_q - 1'b1;
	assign have_top = (count_q != '0);
	assign pop = (state_q == ST_CMP) && have_top && (rd_entry.price <= cur_q);
	assign out_free = !out_valid_q || result.ready;
	assign finish = (state_q == ST_CMP) && !pop && out_free;
	assign full = (count_q == CNT_W'(STACK_DEPTH));
	assign bottom_inc = (bottom_q == PTR_W'(STACK_DEPTH - 1)) ? '0 : bottom_q + 1'b1;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		if (accept) begin
			rd_en = (cnt_eff != '0);
			rd_addr = slot_of(bot_eff, cnt_eff - 1'b1);
		end else if (pop) begin
			rd_en = (count_dec != '0);
			rd_addr = slot_of(bottom_q, count_dec - 1'b1);
		end
	end

	assign wr_en = finish;
	assign wr_addr = full ? bottom_q : slot_of(bottom_q, count_q);
	assign wr_entry = '{index: day_q, price: cur_q};

	always_comb begin
		diff = day_q - rd_entry.index;
		if (!have_top) begin
			span_calc = (day_q == DAY_MAX) ? DAY_MAX : day_q + 1'b1;
		end else if (rd_entry.index > day_q || diff == '0) begin
			span_calc = day_t'(1);
		end else begin
			span_calc = diff;
		end
	end

	sspg_ram #(
		.DEPTH(STACK_DEPTH),
		.WIDTH(ENTRY_W)
	) u_stack (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_entry)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			bottom_q <= '0;
			day_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= cnt_eff;
						bottom_q <= bot_eff;
						if (item.restart) begin
							day_q <= '0;
						end
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					if (pop) begin
						count_q <= count_dec;
					end else if (finish) begin
						if (full) begin
							bottom_q <= bottom_inc;
						end else begin
							count_q <= count_q + 1'b1;
						end
						if (day_q != DAY_MAX) begin
							day_q <= day_q + 1'b1;
						end
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q <= item.price;
		end
		if (finish) begin
			span_q <= span_calc;
			prev_q <= have_top ? rd_entry.price : '0;
			found_q <= have_top;
			ovf_q <= full;
		end
	end

	assign result.valid = out_valid_q;
	assign result.span = span_q;
	assign result.previous_greater = prev_q;
	assign result.greater_found = found_q;
	assign result.stack_overflow = ovf_q;

	`SSPG_ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(STACK_DEPTH))
	`SSPG_ASSERT_NEVER(a_no_rw_overlap, clk, arst_n, wr_en && rd_en)
	`SSPG_ASSERT(a_finish_loads, clk, arst_n, finish |=> result.valid)
	`SSPG_ASSERT(a_span_nonzero, clk, arst_n, result.valid |-> result.span != '0)
	`SSPG_ASSERT(a_prev_zero, clk, arst_n, (result.valid && !result.greater_found) |-> result.previous_greater == '0)
endmodule

>>> hdl/sspg_ram.sv
// simple dual-port ram, one write and one registered read port
// no dependencies
module sspg_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end
endmodule
